### src/blg_pkg.sv
// Package for the battery level gauge: widths, group size, queue sizing
// and the job record passed from the accumulator to the conversion pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package blg_pkg;

  localparam int SampleW         = 10;
  localparam int MvW             = 13;
  localparam int PctW            = 7;
  localparam int OffsetW         = 4;
  localparam int SumW            = 16;
  localparam int CountW          = 7;
  localparam int VolW            = 9;
  localparam int SamplesPerResult = 16;

  localparam logic [OffsetW-1:0] OffsetReset = OffsetW'(4);
  localparam logic [PctW-1:0]    LevelUnset  = PctW'(101);
  localparam logic [PctW-1:0]    PctFull     = PctW'(100);
  localparam logic [MvW-1:0]     MvMax       = MvW'(4800);

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;

  typedef struct packed {
    logic [SampleW-1:0] avg;
    logic               charging;
  } job_t;

endpackage

`default_nettype wire

### src/blg_in_if.sv
// Sample channel of the battery level gauge: valid/ready plus one ADC sample
// and the charging flag. Depends on blg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface blg_in_if;
  logic                       valid;
  logic                       ready;
  logic [blg_pkg::SampleW-1:0] sample;
  logic                       charging;

  modport source (output valid, output sample, output charging, input ready);
  modport sink   (input valid, input sample, input charging, output ready);
endinterface

`default_nettype wire

### src/blg_out_if.sv
// Result channel of the battery level gauge: valid/ready plus average,
// millivolts and percent. Depends on blg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface blg_out_if;
  logic                        valid;
  logic                        ready;
  logic [blg_pkg::SampleW-1:0] average;
  logic [blg_pkg::MvW-1:0]     millivolts;
  logic [blg_pkg::PctW-1:0]    percent;

  modport source (output valid, output average, output millivolts, output percent,
                  input ready);
  modport sink   (input valid, input average, input millivolts, input percent,
                  output ready);
endinterface

`default_nettype wire

### src/battery_level_gauge.sv
// Battery level gauge: accepts one ADC sample per cycle while ready is high.
// Every sixteenth transfer closes a group; its result passes through the job
// queue and the millivolt scaling stage, with the curve lookup and ratchet
// feeding the output register. The sample channel drops ready only when the
// four-entry job queue is full and the offered sample would close a group.
// level_offset resets to 4 and is written directly through cfg_we_i/cfg_wdata_i.
// The first result sets the level; later ones only fall while discharging and
// only rise while charging.
// Depends on blg_pkg, blg_in_if, blg_out_if, blg_front, blg_fifo, blg_back.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_gauge (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  blg_in_if.sink                           in_if,
  blg_out_if.source                        out_if,
  input  wire logic                        cfg_we_i,
  input  wire logic [blg_pkg::OffsetW-1:0] cfg_wdata_i
);

  logic [blg_pkg::OffsetW-1:0] level_offset_q;
  blg_pkg::job_t               push_job, head_job;
  logic                        push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_offset_q <= blg_pkg::OffsetReset;
    end else if (cfg_we_i) begin
      level_offset_q <= cfg_wdata_i;
    end
  end

  blg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .full_i (full),
    .job_o  (push_job),
    .push_o (push)
  );

  blg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  blg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .level_offset_i (level_offset_q),
    .job_i          (head_job),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_if         (out_if)
  );

endmodule

`default_nettype wire

### src/blg_front.sv
// Front end: accepts samples, accumulates each group and hands the group
// average with its charging flag to the job queue. Depends on blg_pkg, blg_in_if.
`timescale 1ns / 1ps
`default_nettype none

module blg_front (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  blg_in_if.sink      in_if,
  input  wire logic   full_i,
  output blg_pkg::job_t job_o,
  output logic        push_o
);

  localparam logic [blg_pkg::CountW-1:0] LastCount =
    blg_pkg::CountW'(blg_pkg::SamplesPerResult - 1);

  logic [blg_pkg::SumW-1:0]   sum_q, sum_d;
  logic [blg_pkg::CountW-1:0] count_q;
  logic                       last;
  logic                       xfer;
  logic [blg_pkg::SumW-1:0]   quot;

  assign last        = (count_q == LastCount);
  assign in_if.ready = !full_i || !last;
  assign xfer        = in_if.valid && in_if.ready;
  assign sum_d       = sum_q + blg_pkg::SumW'(in_if.sample);
  assign quot        = sum_d / blg_pkg::SumW'(blg_pkg::SamplesPerResult);

  assign push_o         = xfer && last;
  assign job_o.avg      = quot[blg_pkg::SampleW-1:0];
  assign job_o.charging = in_if.charging;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (xfer) begin
      if (last) begin
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_d;
        count_q <= count_q + blg_pkg::CountW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/blg_fifo.sv
// Short job queue between the accumulator and the conversion pipeline.
// Depends on blg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blg_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire blg_pkg::job_t job_i,
  input  wire logic          pop_i,
  output blg_pkg::job_t      job_o,
  output logic               full_o,
  output logic               empty_o
);

  blg_pkg::job_t                mem_q [blg_pkg::FifoDepth];
  logic [blg_pkg::FifoPtrW-1:0] wptr_q, rptr_q;
  logic [blg_pkg::FifoCntW-1:0] count_q;

  assign full_o  = (count_q == blg_pkg::FifoCntW'(blg_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + blg_pkg::FifoPtrW'(1);
      if (pop_i)  rptr_q <= rptr_q + blg_pkg::FifoPtrW'(1);
      if (push_i && !pop_i) count_q <= count_q + blg_pkg::FifoCntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - blg_pkg::FifoCntW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= blg_pkg::FifoCntW'(blg_pkg::FifoDepth))
    else $error("job queue over capacity");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty job queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("push into full job queue");

endmodule

`default_nettype wire

### src/blg_back.sv
// Back end: converts queued averages to millivolts, maps them through the
// discharge curve and applies the level ratchet. Depends on blg_pkg, blg_out_if.
`timescale 1ns / 1ps
`default_nettype none

module blg_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [blg_pkg::OffsetW-1:0]   level_offset_i,
  input  wire blg_pkg::job_t                 job_i,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  blg_out_if.source                          out_if
);

  function automatic logic [blg_pkg::PctW-1:0] curve_pct(input logic [blg_pkg::VolW-1:0] vol);
    logic [31:0] v;
    logic [31:0] r;
    begin
      v = 32'(vol);
      if (v >= 32'd420)      r = 32'd100;
      else if (v >= 32'd397) r = 32'd90 + (((v - 32'd397) * 32'd7130) >> 14);
      else if (v >= 32'd387) r = 32'd80 + (v - 32'd387);
      else if (v >= 32'd379) r = 32'd70 + (((v - 32'd379) * 32'd10) >> 3);
      else if (v >= 32'd373) r = 32'd60 + (((v - 32'd373) * 32'd430) >> 8);
      else if (v >= 32'd368) r = 32'd50 + ((v - 32'd368) << 1);
      else if (v >= 32'd342) r = 32'd5 + (((v - 32'd342) * 32'd95175) >> 16);
      else if (v >= 32'd300) r = ((v - 32'd300) * 32'd1955) >> 14;
      else                   r = 32'd0;
      curve_pct = r[blg_pkg::PctW-1:0];
    end
  endfunction

  logic                        a_valid_q;
  logic [blg_pkg::SampleW-1:0] a_avg_q;
  logic                        a_chg_q;
  logic [blg_pkg::MvW-1:0]     a_mv_q;

  logic                        b_valid_q;
  logic [blg_pkg::SampleW-1:0] b_avg_q;
  logic [blg_pkg::MvW-1:0]     b_mv_q;
  logic [blg_pkg::PctW-1:0]    b_pct_q;

  logic [blg_pkg::PctW-1:0]    last_level_q, last_level_d;
  logic [blg_pkg::PctW-1:0]    pct_raw, pct_out;
  logic [blg_pkg::VolW-1:0]    vol;
  logic [blg_pkg::MvW-1:0]     mv_d;
  logic [41:0]                 mv_prod;
  logic [25:0]                 vol_prod;
  logic                        b_adv, a_adv;

  assign b_adv = !b_valid_q || out_if.ready;
  assign a_adv = !a_valid_q || b_adv;
  assign pop_o = a_adv && !empty_i;

  // scale by 1200/1023 with a reciprocal multiply, exact over all averages, then times four
  assign mv_prod  = 42'(job_i.avg) * 42'd2519043600;
  assign mv_d     = blg_pkg::MvW'({mv_prod[41:31], 2'b00});
  assign vol_prod = 26'(a_mv_q) * 26'd6554;

  always_comb begin
    vol     = vol_prod[24:16] + blg_pkg::VolW'(level_offset_i);
    pct_raw = curve_pct(vol);
    pct_out      = pct_raw;
    last_level_d = last_level_q;
    if (!a_chg_q) begin
      if (pct_raw <= last_level_q) last_level_d = pct_raw;
      else                         pct_out      = last_level_q;
    end else begin
      if (pct_raw >= last_level_q || last_level_q == blg_pkg::LevelUnset) begin
        last_level_d = pct_raw;
      end else begin
        pct_out = last_level_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_avg_q <= job_i.avg;
      a_chg_q <= job_i.charging;
      a_mv_q  <= mv_d;
    end
    if (b_adv && a_valid_q) begin
      b_avg_q <= a_avg_q;
      b_mv_q  <= a_mv_q;
      b_pct_q <= pct_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      b_valid_q    <= 1'b0;
      last_level_q <= blg_pkg::LevelUnset;
    end else begin
      if (a_adv) a_valid_q <= !empty_i;
      if (b_adv) b_valid_q <= a_valid_q;
      if (b_adv && a_valid_q) last_level_q <= last_level_d;
    end
  end

  assign out_if.valid      = b_valid_q;
  assign out_if.average    = b_avg_q;
  assign out_if.millivolts = b_mv_q;
  assign out_if.percent    = b_pct_q;

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (b_pct_q <= blg_pkg::PctFull))
    else $error("percent above full scale");
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_level_q <= blg_pkg::LevelUnset)
    else $error("stored level out of range");
  a_mv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (b_mv_q <= blg_pkg::MvMax))
    else $error("millivolts above full scale");

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for battery_level_gauge: streams ADC samples, predicts each averaged
// reading and its ratcheted charge percent, and checks every reading on arrival.
// Depends on blg_pkg, blg_in_if, blg_out_if and the gauge RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned QuietLimit     = 2000;
  localparam int unsigned GroupsPerPhase = 25;

  class charge_tracker;
    logic [blg_pkg::SumW-1:0]    sum_acc;
    logic [blg_pkg::CountW-1:0]  taken;
    logic [blg_pkg::PctW-1:0]    held_level;
    logic [blg_pkg::OffsetW-1:0] offset;
    logic [blg_pkg::SampleW-1:0] due_average[$];
    logic [blg_pkg::MvW-1:0]     due_millivolts[$];
    logic [blg_pkg::PctW-1:0]    due_percent[$];
    int unsigned                 errors;
    int unsigned                 samples_seen;
    int unsigned                 readings_seen;

    function new();
      sum_acc       = '0;
      taken         = '0;
      held_level    = blg_pkg::LevelUnset;
      offset        = blg_pkg::OffsetReset;
      errors        = 0;
      samples_seen  = 0;
      readings_seen = 0;
    endfunction

    function int unsigned pending();
      return due_average.size();
    endfunction

    function int unsigned soc_from_vol(int unsigned vol);
      if (vol >= 420) return 100;
      if (vol >= 397) return 90 + (vol - 397) * 10 / 23;
      if (vol >= 387) return 80 + (vol - 387) * 10 / 10;
      if (vol >= 379) return 70 + (vol - 379) * 10 / 8;
      if (vol >= 373) return 60 + (vol - 373) * 10 / 6;
      if (vol >= 368) return 50 + (vol - 368) * 10 / 5;
      if (vol >= 342) return 5 + (vol - 342) * 45 / 31;
      if (vol >= 300) return (vol - 300) * 5 / 42;
      return 0;
    endfunction

    function void take_sample(logic [blg_pkg::SampleW-1:0] s, logic charging);
      int unsigned avg;
      int unsigned mv;
      int unsigned vol;
      int unsigned pct;
      samples_seen++;
      sum_acc = sum_acc + blg_pkg::SumW'(s);
      taken   = taken + 1'b1;
      if (taken < blg_pkg::CountW'(blg_pkg::SamplesPerResult)) return;
      avg     = (32'(sum_acc) / 32'(taken)) & 32'h3FF;
      sum_acc = '0;
      taken   = '0;
      mv  = avg * 3600 / 1023 / 3 * 4;
      vol = mv / 10 + 32'(offset);
      pct = soc_from_vol(vol);
      if (!charging) begin
        if (pct <= 32'(held_level)) held_level = blg_pkg::PctW'(pct);
        else if (held_level != blg_pkg::LevelUnset) pct = 32'(held_level);
      end else begin
        if (pct >= 32'(held_level)) held_level = blg_pkg::PctW'(pct);
        else if (held_level != blg_pkg::LevelUnset) pct = 32'(held_level);
        else held_level = blg_pkg::PctW'(pct);
      end
      due_average.push_back(blg_pkg::SampleW'(avg));
      due_millivolts.push_back(blg_pkg::MvW'(mv));
      due_percent.push_back(blg_pkg::PctW'(pct));
    endfunction

    function void check_reading(logic [blg_pkg::SampleW-1:0] average,
                                logic [blg_pkg::MvW-1:0] millivolts,
                                logic [blg_pkg::PctW-1:0] percent);
      logic [blg_pkg::SampleW-1:0] want_avg;
      logic [blg_pkg::MvW-1:0]     want_mv;
      logic [blg_pkg::PctW-1:0]    want_pct;
      if (due_average.size() == 0) begin
        $error("reading with none pending: average %0d, millivolts %0d, percent %0d",
               average, millivolts, percent);
        errors++;
        return;
      end
      want_avg = due_average.pop_front();
      want_mv  = due_millivolts.pop_front();
      want_pct = due_percent.pop_front();
      readings_seen++;
      if (average !== want_avg) begin
        $error("average mismatch: expected %0d, actual %0d", want_avg, average);
        errors++;
      end
      if (millivolts !== want_mv) begin
        $error("millivolts mismatch: expected %0d, actual %0d", want_mv, millivolts);
        errors++;
      end
      if (percent !== want_pct) begin
        $error("percent mismatch: expected %0d, actual %0d", want_pct, percent);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [blg_pkg::OffsetW-1:0] cfg_wdata_i;

  blg_in_if  samples ();
  blg_out_if readings ();

  battery_level_gauge u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (samples),
    .out_if      (readings),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  charge_tracker gauge = new();

  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned offsets_set  = 0;
  bit          long_hold    = 1'b0;
  int          walk_level   = 780;
  bit          walk_charging = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (samples.valid === 1'b1 && samples.ready === 1'b1)
      gauge.take_sample(samples.sample, samples.charging);
    if (readings.valid === 1'b1 && readings.ready === 1'b1)
      gauge.check_reading(readings.average, readings.millivolts, readings.percent);
    if ((samples.valid === 1'b1 && samples.ready === 1'b1) ||
        (readings.valid === 1'b1 && readings.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("Timeout: no transfer for %0d cycles", QuietLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin
    readings.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        readings.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end
      readings.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_sample(input logic [blg_pkg::SampleW-1:0] s, input logic charging);
    while ($urandom_range(99) < idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk_i);
    end
    samples.valid    <= 1'b1;
    samples.sample   <= s;
    samples.charging <= charging;
    @(negedge clk_i);
    while (samples.ready !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_group(input int centre, input int spread, input bit charging);
    int value;
    bit flag;
    for (int i = 0; i < blg_pkg::SamplesPerResult; i++) begin
      value = centre + $urandom_range(2 * spread) - spread;
      if (value < 0) value = 0;
      if (value > 1023) value = 1023;
      flag = ($urandom_range(99) < 10) ? !charging : charging;
      if (i == blg_pkg::SamplesPerResult - 1) flag = charging;
      send_sample(blg_pkg::SampleW'(value), flag);
    end
  endtask

  task automatic run_groups(input int unsigned count);
    for (int unsigned g = 0; g < count; g++) begin
      if ($urandom_range(99) < 15) walk_charging = !walk_charging;
      if ($urandom_range(99) < 25) walk_level = $urandom_range(1023);
      else if (walk_charging) walk_level = walk_level + $urandom_range(12) - 3;
      else walk_level = walk_level - $urandom_range(12) + 3;
      if (walk_level < 0) walk_level = 0;
      if (walk_level > 1023) walk_level = 1023;
      send_group(walk_level, ($urandom_range(99) < 10) ? 1023 : $urandom_range(20),
                 walk_charging);
    end
    samples.valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (gauge.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [blg_pkg::OffsetW-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gauge.offset = value;
    offsets_set++;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [blg_pkg::OffsetW-1:0] value,
                           input int unsigned idle, input int unsigned stall);
    write_offset(value);
    idle_pct  = idle;
    stall_pct = stall;
    run_groups(GroupsPerPhase);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    samples.valid    = 1'b0;
    samples.sample   = '0;
    samples.charging = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first reading while charging sets the level from full scale
    send_group(1023, 0, 1'b1);
    // alternate both extremes: mid-scale average, level falls
    for (int i = 0; i < blg_pkg::SamplesPerResult; i++)
      send_sample((i % 2) ? blg_pkg::SampleW'(1023) : blg_pkg::SampleW'(0), 1'b0);
    // full scale while discharging: hold the stored level
    send_group(1023, 0, 1'b0);
    samples.valid <= 1'b0;

    write_offset(blg_pkg::OffsetW'(0));
    long_hold = 1'b1;
    run_groups(8);
    run_phase(blg_pkg::OffsetW'(15), 0, 0);
    run_phase(blg_pkg::OffsetW'($urandom_range(15)), 87, 0);
    run_phase(blg_pkg::OffsetW'($urandom_range(15)), 0, 87);
    run_phase(blg_pkg::OffsetW'(9), 27, 27);

    settle();
    $display("Covered %0d samples and %0d readings across four pacing phases,",
             gauge.samples_seen, gauge.readings_seen);
    $display("a long output stall and %0d offset settings", offsets_set);
    if (gauge.errors == 0 && gauge.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
